[design/tga_pixel_stream_decoder_assert.svh]
// Assertion macros for the TGA pixel stream decoder.
`ifndef TGA_PIXEL_STREAM_DECODER_ASSERT_SVH
`define TGA_PIXEL_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TPD_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPD_ASSERT(label, clk, rst, prop, msg)
`define TPD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[design/tpd_pkg.sv]
// Package: shared types and constants of the TGA pixel stream decoder.
`default_nettype none
package tpd_pkg;
   localparam int unsigned CSR_AW = 5;
   localparam logic [2:0] REG_KIND = 3'd0;
   localparam logic [2:0] REG_PDEPTH = 3'd1;
   localparam logic [2:0] REG_MDEPTH = 3'd2;
   localparam logic [2:0] REG_MFIRST = 3'd3;
   localparam logic [2:0] REG_MCOUNT = 3'd4;
   localparam logic [2:0] REG_WIDTH = 3'd5;
   localparam logic [2:0] REG_HEIGHT = 3'd6;
   localparam logic [2:0] REG_LAYOUT = 3'd7;

   localparam logic [2:0] DEPTH_8 = 3'd0;
   localparam logic [2:0] DEPTH_15 = 3'd1;
   localparam logic [2:0] DEPTH_16 = 3'd2;
   localparam logic [2:0] DEPTH_24 = 3'd3;
   localparam logic [2:0] DEPTH_32 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   function automatic logic [2:0] depth_code(input logic [2:0] c);
      return (c > DEPTH_32) ? DEPTH_32 : c;
   endfunction

   function automatic logic [2:0] depth_bytes(input logic [2:0] code);
      logic [2:0] r;
      case (code)
         DEPTH_8: r = 3'd1;
         DEPTH_15, DEPTH_16: r = 3'd2;
         DEPTH_24: r = 3'd3;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] to_bgra(input logic [31:0] v, input logic [2:0] code,
                                           input logic alpha_bit);
      logic [7:0] b0, b1, b2, bl, gr, rd, al;
      b0 = v[7:0];
      b1 = v[15:8];
      b2 = v[23:16];
      al = 8'hFF;
      if (code == DEPTH_8) begin
         bl = b0; gr = b0; rd = b0;
      end else if (code == DEPTH_15 || code == DEPTH_16) begin
         rd = {b1[6:2], 3'b000};
         gr = {b1[1:0], b0[7:5], 3'b000};
         bl = {b0[4:0], 3'b000};
         if (code == DEPTH_16 && alpha_bit) al = b1[7] ? 8'hFF : 8'h00;
      end else begin
         bl = b0; gr = b1; rd = b2;
         if (code == DEPTH_32) al = v[31:24];
      end
      return {al, rd, gr, bl};
   endfunction
endpackage
`default_nettype wire

[design/tpd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tpd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[design/tga_pixel_stream_decoder.sv]
// Top level: TGA body decoder, palette load, pixel decode and row segmentation.
//
// Usage:
//  - req_ channel carries one stream byte per transaction; req_image_start
//    marks the first byte of a new image and clears all decode state.
//  - The colour map bytes come first (map_count entries), then pixel data.
//  - rsp_ channel carries one row segment per transaction: BGRA colour,
//    destination row, first column and run length. rsp_last_segment marks
//    the final segment caused by one byte; rsp_image_done the image end.
//  - Registers are written on the APB port; the user must write them only
//    while the block is idle, which the block itself does not enforce.
// Sequence:
//  - A byte that only gathers or loads the map leaves the block idle.
//  - A pixel-completing byte forms the pixel, then reads the palette in
//    ST_LOOKUP (registered RAM), then emits its segments one by one in
//    ST_EMIT, each held in the output register until taken; a replicated
//    run spanning k rows yields k segments. The palette is one 32-bit RAM.
// Reset: synchronous, clears control state and loads register defaults.
// Palette contents are undefined until loaded for the current image.
// A stalled rsp_ready holds the current segment and blocks new bytes.
`default_nettype none
module tga_pixel_stream_decoder #(
   parameter int unsigned MAP_ENTRIES   = 256,
   parameter int unsigned MAX_DIMENSION = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_image_start,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_blue,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_alpha,
   output logic [11:0]                      rsp_dest_row,
   output logic [11:0]                      rsp_column,
   output logic [7:0]                       rsp_run_length,
   output logic                             rsp_last_segment,
   output logic                             rsp_image_done,
   output logic                             rsp_index_error,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [tpd_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import tpd_pkg::*;
`include "tga_pixel_stream_decoder_assert.svh"

   localparam int unsigned MAW = $clog2(MAP_ENTRIES);
   localparam int unsigned DW = $clog2(MAX_DIMENSION + 1);

   // ---------------- configuration registers ----------------
   logic [2:0]  kind_ff, pdepth_ff, mdepth_ff, layout_ff;
   logic [7:0]  mfirst_ff;
   logic [8:0]  mcount_ff;
   logic [12:0] width_ff, height_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 3'd1; pdepth_ff <= 3'd3; mdepth_ff <= 3'd3; mfirst_ff <= '0;
         mcount_ff <= '0; width_ff <= 13'd4; height_ff <= 13'd1; layout_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KIND:   kind_ff   <= pwdata[2:0];
            REG_PDEPTH: pdepth_ff <= pwdata[2:0];
            REG_MDEPTH: mdepth_ff <= pwdata[2:0];
            REG_MFIRST: mfirst_ff <= pwdata[7:0];
            REG_MCOUNT: mcount_ff <= pwdata[8:0];
            REG_WIDTH:  width_ff  <= pwdata[12:0];
            REG_HEIGHT: height_ff <= pwdata[12:0];
            REG_LAYOUT: layout_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_KIND:   prdata = {29'd0, kind_ff};
         REG_PDEPTH: prdata = {29'd0, pdepth_ff};
         REG_MDEPTH: prdata = {29'd0, mdepth_ff};
         REG_MFIRST: prdata = {24'd0, mfirst_ff};
         REG_MCOUNT: prdata = {23'd0, mcount_ff};
         REG_WIDTH:  prdata = {19'd0, width_ff};
         REG_HEIGHT: prdata = {19'd0, height_ff};
         REG_LAYOUT: prdata = {29'd0, layout_ff};
         default:    prdata = '0;
      endcase
   end

   // saturated geometry
   logic [DW-1:0] w_now, h_now;
   always_comb begin
      if (width_ff < 13'd4) w_now = DW'(4);
      else if (32'(width_ff) > MAX_DIMENSION) w_now = DW'(MAX_DIMENSION);
      else w_now = DW'(width_ff);
      if (height_ff < 13'd1) h_now = DW'(1);
      else if (32'(height_ff) > MAX_DIMENSION) h_now = DW'(MAX_DIMENSION);
      else h_now = DW'(height_ff);
   end

   // ---------------- decode state ----------------
   state_type     state_ff, state_in;
   logic          phase_ff, phase_in;
   logic [8:0]    loaded_ff, loaded_in;
   logic [23:0]   gather_ff, gather_in;
   logic [1:0]    bpos_ff, bpos_in;
   logic [7:0]    prem_ff, prem_in;
   logic          prep_ff, prep_in;
   logic [DW-1:0] col_ff, col_in, frow_ff, frow_in, brow_ff, brow_in, rdone_ff, rdone_in;
   logic          fin_ff, fin_in;
   // pending pixel
   logic [31:0]   colour_ff, colour_in;
   logic          err_ff, err_in, usepal_ff, usepal_in;
   logic [7:0]    count_ff, count_in;
   // output register
   logic          ov_ff, ov_in;
   logic [31:0]   ocol_ff, ocol_in;
   logic [11:0]   orow_ff, orow_in, ocolumn_ff, ocolumn_in;
   logic [7:0]    olen_ff, olen_in;
   logic          olast_ff, olast_in, odone_ff, odone_in, oerr_ff, oerr_in;

   // palette RAM
   logic           pal_we;
   logic [MAW-1:0] pal_wa, pal_ra, ra_ff, ra_in;
   logic [31:0]    pal_wd, pal_rd;

   tpd_ram #(.WIDTH(32), .DEPTH(MAP_ENTRIES)) u_palette (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(pal_wa),
      .wr_data(pal_wd),
      .rd_addr(pal_ra),
      .rd_data(pal_rd)
   );
   assign pal_ra = ra_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= 1'b0; loaded_ff <= '0; gather_ff <= '0;
         bpos_ff <= '0; prem_ff <= '0; prep_ff <= 1'b0; col_ff <= '0; frow_ff <= '0;
         brow_ff <= '0; rdone_ff <= '0; fin_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; loaded_ff <= loaded_in;
         gather_ff <= gather_in; bpos_ff <= bpos_in; prem_ff <= prem_in;
         prep_ff <= prep_in; col_ff <= col_in; frow_ff <= frow_in; brow_ff <= brow_in;
         rdone_ff <= rdone_in; fin_ff <= fin_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      colour_ff <= colour_in; err_ff <= err_in; usepal_ff <= usepal_in;
      count_ff <= count_in; ra_ff <= ra_in;
      ocol_ff <= ocol_in; orow_ff <= orow_in; ocolumn_ff <= ocolumn_in;
      olen_ff <= olen_in; olast_ff <= olast_in; odone_ff <= odone_in; oerr_ff <= oerr_in;
   end

   // byte path helpers
   logic          accept;
   logic [2:0]    md, pd;
   logic [31:0]   full;
   logic          rle, mapped;
   logic [31:0]   value;
   logic [32:0]   idx_wide;
   // emit helpers
   logic [DW-1:0] seg, room, col_next, frow_step, drow;
   logic [DW:0]   frow_sum;
   logic [2:0]    istep;
   logic          rsp_free;

   assign rsp_free = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; loaded_in = loaded_ff;
      gather_in = gather_ff; bpos_in = bpos_ff; prem_in = prem_ff; prep_in = prep_ff;
      col_in = col_ff; frow_in = frow_ff; brow_in = brow_ff; rdone_in = rdone_ff;
      fin_in = fin_ff;
      colour_in = colour_ff; err_in = err_ff; usepal_in = usepal_ff;
      count_in = count_ff; ra_in = ra_ff;
      ov_in = ov_ff && !rsp_ready;
      ocol_in = ocol_ff; orow_in = orow_ff; ocolumn_in = ocolumn_ff; olen_in = olen_ff;
      olast_in = olast_ff; odone_in = odone_ff; oerr_in = oerr_ff;
      pal_we = 1'b0; pal_wa = '0; pal_wd = '0;
      md = depth_code(mdepth_ff);
      pd = depth_code(pdepth_ff);
      rle = kind_ff >= 3'd3;
      mapped = (kind_ff == 3'd0) || (kind_ff == 3'd3);
      full = '0; value = '0; idx_wide = '0;
      seg = '0; room = '0; col_next = '0; frow_step = '0; drow = '0; frow_sum = '0;
      istep = 3'd1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_image_start) begin
                  phase_in = 1'b0; loaded_in = '0; gather_in = '0; bpos_in = '0;
                  prem_in = '0; prep_in = 1'b0; col_in = '0; frow_in = '0;
                  brow_in = '0; rdone_in = '0; fin_in = 1'b0;
               end
               if (!fin_in) begin
                  full = {8'd0, gather_in} | (32'(req_data_byte) << {bpos_in, 3'b000});
                  if (!phase_in && loaded_in < mcount_ff) begin
                     if (3'(bpos_in) + 3'd1 < depth_bytes(md)) begin
                        gather_in = full[23:0]; bpos_in = bpos_in + 2'd1;
                     end else begin
                        gather_in = '0; bpos_in = '0;
                        if (32'(loaded_in) < MAP_ENTRIES) begin
                           pal_we = 1'b1; pal_wa = MAW'(loaded_in);
                           pal_wd = to_bgra(full, md, 1'b1);
                        end
                        loaded_in = loaded_in + 9'd1;
                        if (loaded_in >= mcount_ff) phase_in = 1'b1;
                     end
                  end else begin
                     if (!phase_in) begin
                        phase_in = 1'b1; gather_in = '0; bpos_in = '0;
                        full = 32'(req_data_byte);
                     end
                     if (rle && prem_in == 8'd0 && bpos_in == 2'd0) begin
                        prep_in = req_data_byte[7];
                        prem_in = {1'b0, req_data_byte[6:0]} + 8'd1;
                     end else if (3'(bpos_in) + 3'd1 < depth_bytes(pd)) begin
                        gather_in = full[23:0]; bpos_in = bpos_in + 2'd1;
                     end else begin
                        gather_in = '0; bpos_in = '0;
                        case (pd)
                           DEPTH_8: value = {24'd0, full[7:0]};
                           DEPTH_15, DEPTH_16: value = {16'd0, full[15:0]};
                           DEPTH_24: value = {8'd0, full[23:0]};
                           default: value = full;
                        endcase
                        idx_wide = {1'b0, value} - 33'(mfirst_ff);
                        err_in = 1'b0; usepal_in = 1'b0;
                        colour_in = to_bgra(full, pd, 1'b0);
                        if (mapped) begin
                           if (idx_wide[32] || idx_wide[31:0] >= 32'(loaded_in) ||
                               idx_wide[31:0] >= MAP_ENTRIES) begin
                              err_in = 1'b1; colour_in = '0;
                           end else begin
                              usepal_in = 1'b1; ra_in = MAW'(idx_wide[31:0]);
                           end
                        end
                        count_in = 8'd1;
                        if (rle && prem_in != 8'd0) begin
                           if (prep_in) begin
                              count_in = prem_in; prem_in = '0;
                           end else prem_in = prem_in - 8'd1;
                        end
                        state_in = ST_LOOKUP;
                     end
                  end
               end
            end
         end
         ST_LOOKUP: begin
            // palette data valid this cycle
            if (usepal_ff) colour_in = pal_rd;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (fin_ff) begin
               // run cut at image end; the last segment already carried the end flags
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               room = (col_ff < w_now) ? (w_now - col_ff) : DW'(1);
               seg = (room > DW'(count_ff)) ? DW'(count_ff) : room;
               case (layout_ff[2:1])
                  2'd1: istep = 3'd2;
                  2'd2: istep = 3'd4;
                  default: istep = 3'd1;
               endcase
               drow = layout_ff[0] ? frow_ff : (h_now - DW'(1) - frow_ff);
               ov_in = 1'b1;
               ocol_in = colour_ff; orow_in = drow[11:0]; ocolumn_in = col_ff[11:0];
               olen_in = seg[7:0]; oerr_in = err_ff; odone_in = 1'b0;
               col_next = col_ff + seg;
               count_in = count_ff - seg[7:0];
               col_in = col_next;
               if (col_next >= w_now) begin
                  col_in = '0;
                  frow_sum = {1'b0, frow_ff} + (DW+1)'(istep);
                  frow_step = frow_sum[DW-1:0];
                  if (frow_sum >= (DW+1)'(h_now)) begin
                     brow_in = brow_ff + DW'(1); frow_step = brow_in;
                  end
                  frow_in = frow_step;
                  rdone_in = rdone_ff + DW'(1);
                  if (rdone_in >= h_now) begin
                     fin_in = 1'b1; odone_in = 1'b1;
                  end
               end
               olast_in = (count_in == 8'd0) || fin_in;
               if (olast_in) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = ov_ff;
   assign rsp_blue = ocol_ff[7:0];
   assign rsp_green = ocol_ff[15:8];
   assign rsp_red = ocol_ff[23:16];
   assign rsp_alpha = ocol_ff[31:24];
   assign rsp_dest_row = orow_ff;
   assign rsp_column = ocolumn_ff;
   assign rsp_run_length = olen_ff;
   assign rsp_last_segment = olast_ff;
   assign rsp_image_done = odone_ff;
   assign rsp_index_error = oerr_ff;

   `TPD_ASSERT(a_ready_idle, clock, reset, req_ready |-> state_ff == ST_IDLE,
               "byte taken while a pixel is in flight")
   `TPD_ASSERT(a_len_nonzero, clock, reset, rsp_valid |-> rsp_run_length != 8'd0,
               "empty segment")
   `TPD_ASSERT(a_err_black, clock, reset, (rsp_valid && rsp_index_error) |-> ocol_ff == 32'd0,
               "index error with colour")
   `TPD_ASSERT(a_done_last, clock, reset, (rsp_valid && rsp_image_done) |-> rsp_last_segment,
               "image end not last segment")
   `TPD_ASSERT_RST(a_reset_idle, clock, $past(reset) |-> !rsp_valid,
                   "output valid after reset")
endmodule
`default_nettype wire

[test/tga_pixel_stream_decoder_tb.sv]
// Testbench for the TGA pixel stream decoder: queued stream bytes, predicted row segments.
`default_nettype none
module tga_pixel_stream_decoder_tb;
   import tpd_pkg::*;

   // one row segment as the block should report it
   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic [11:0] dest_row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic        last_segment;
      logic        image_done;
      logic        index_error;
   } segment_t;

   // one stream byte waiting for the request channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } stream_byte_t;

   localparam int unsigned PALETTE_SIZE = 256;
   localparam int unsigned DIM_LIMIT = 4096;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_image_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_blue, rsp_green, rsp_red, rsp_alpha;
   logic [11:0] rsp_dest_row, rsp_column;
   logic [7:0] rsp_run_length;
   logic rsp_last_segment, rsp_image_done, rsp_index_error;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic pready;

   tga_pixel_stream_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_image_start(req_image_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue(rsp_blue), .rsp_green(rsp_green), .rsp_red(rsp_red),
      .rsp_alpha(rsp_alpha), .rsp_dest_row(rsp_dest_row), .rsp_column(rsp_column),
      .rsp_run_length(rsp_run_length), .rsp_last_segment(rsp_last_segment),
      .rsp_image_done(rsp_image_done), .rsp_index_error(rsp_index_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // 12 time unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stream_byte_t pending_bytes[$];
   segment_t expected_segments[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_pct = 20;   // chance in a hundred that a side idles

   // ---------------------------------------------------------------------
   // Decoder shadow: register copies and decode state
   // ---------------------------------------------------------------------
   int unsigned cfg_kind = 1, cfg_pixel_depth = 3, cfg_map_depth = 3;
   int unsigned cfg_map_first = 0, cfg_map_count = 0;
   int unsigned cfg_width = 4, cfg_height = 1, cfg_layout = 0;

   logic [31:0] palette_copy [PALETTE_SIZE];
   int unsigned in_pixel_phase, entries_loaded, gathered, gather_pos;
   int unsigned packet_left, packet_is_repeat;
   int unsigned col_pos, src_row, row_base, row_count, image_finished;

   function automatic void clear_decode();
      in_pixel_phase = 0; entries_loaded = 0; gathered = 0; gather_pos = 0;
      packet_left = 0; packet_is_repeat = 0;
      col_pos = 0; src_row = 0; row_base = 0; row_count = 0; image_finished = 0;
   endfunction

   // undefined depth codes behave as 32 bits
   function automatic int unsigned clamp_depth(int unsigned code);
      return (code > DEPTH_32) ? DEPTH_32 : code;
   endfunction

   function automatic int unsigned bytes_per_pixel(int unsigned code);
      int unsigned c;
      c = clamp_depth(code);
      if (c == DEPTH_8) return 1;
      if (c <= DEPTH_16) return 2;
      if (c == DEPTH_24) return 3;
      return 4;
   endfunction

   // raw pixel word to {A,R,G,B}; 16-bit alpha bit honored only for map entries
   function automatic logic [31:0] pixel_to_bgra(logic [31:0] v, int unsigned code,
                                                 bit use_alpha_bit);
      logic [7:0] bl, gr, rd, al;
      al = 8'hFF;
      if (code == DEPTH_8) begin
         bl = v[7:0]; gr = v[7:0]; rd = v[7:0];
      end else if (code <= DEPTH_16) begin
         rd = {v[14:10], 3'b000};
         gr = {v[9:5], 3'b000};
         bl = {v[4:0], 3'b000};
         if (code == DEPTH_16 && use_alpha_bit) al = v[15] ? 8'hFF : 8'h00;
      end else begin
         bl = v[7:0]; gr = v[15:8]; rd = v[23:16];
         if (code == DEPTH_32) al = v[31:24];
      end
      return {al, rd, gr, bl};
   endfunction

   function automatic void next_source_row(int unsigned h);
      int unsigned lace;
      lace = (cfg_layout >> 1) & 3;
      src_row += (lace == 2) ? 4 : ((lace == 1) ? 2 : 1);
      if (src_row >= h) begin
         row_base++;
         src_row = row_base;
      end
      row_count++;
   endfunction

   // split a run of identical pixels into row segments
   function automatic void split_run(int unsigned count, logic [31:0] colour, bit err);
      int unsigned w, h, seg, drow;
      segment_t s;
      segment_t segs[$];
      w = (cfg_width < 4) ? 4 : ((cfg_width > DIM_LIMIT) ? DIM_LIMIT : cfg_width);
      h = (cfg_height < 1) ? 1 : ((cfg_height > DIM_LIMIT) ? DIM_LIMIT : cfg_height);
      while (count > 0 && !image_finished) begin
         seg = (col_pos < w) ? w - col_pos : 1;
         if (seg > count) seg = count;
         drow = (cfg_layout & 1) ? src_row : (h - 1 - src_row);
         s = '0;
         {s.alpha, s.red, s.green, s.blue} = colour;
         s.dest_row = drow[11:0];
         s.column = col_pos[11:0];
         s.run_length = seg[7:0];
         s.index_error = err;
         col_pos += seg;
         count -= seg;
         if (col_pos >= w) begin
            col_pos = 0;
            next_source_row(h);
            if (row_count >= h) begin
               image_finished = 1;
               s.image_done = 1'b1;
            end
         end
         segs.insert(segs.size(), s);
      end
      if (segs.size() > 0) segs[segs.size()-1].last_segment = 1'b1;
      foreach (segs[i]) expected_segments.insert(expected_segments.size(), segs[i]);
   endfunction

   // expected segments for one accepted stream byte
   function automatic void decode_byte(logic [7:0] data, logic start);
      int unsigned pd, md, word, value, idx, count;
      logic [31:0] colour;
      bit err, rle, mapped;
      err = 0; count = 1;
      if (start) clear_decode();
      if (image_finished) return;
      if (in_pixel_phase == 0) begin
         if (entries_loaded < cfg_map_count) begin
            md = clamp_depth(cfg_map_depth);
            word = gathered | (int'(data) << (8 * (gather_pos & 3)));
            if (gather_pos + 1 < bytes_per_pixel(md)) begin
               gathered = word & 32'hFF_FFFF;
               gather_pos = (gather_pos + 1) & 3;
               return;
            end
            gathered = 0; gather_pos = 0;
            if (entries_loaded < PALETTE_SIZE)
               palette_copy[entries_loaded] = pixel_to_bgra(word, md, 1'b1);
            entries_loaded++;
            if (entries_loaded >= cfg_map_count) in_pixel_phase = 1;
            return;
         end
         in_pixel_phase = 1; gathered = 0; gather_pos = 0;
      end
      rle = cfg_kind >= 3;
      mapped = (cfg_kind == 0) || (cfg_kind == 3);
      if (rle && packet_left == 0 && gather_pos == 0) begin
         packet_is_repeat = data[7];
         packet_left = int'(data[6:0]) + 1;
         return;
      end
      pd = clamp_depth(cfg_pixel_depth);
      word = gathered | (int'(data) << (8 * (gather_pos & 3)));
      if (gather_pos + 1 < bytes_per_pixel(pd)) begin
         gathered = word & 32'hFF_FFFF;
         gather_pos = (gather_pos + 1) & 3;
         return;
      end
      gathered = 0; gather_pos = 0;
      if (mapped) begin
         value = (pd == DEPTH_8) ? (word & 32'hFF) : (pd <= DEPTH_16) ? (word & 32'hFFFF) :
                 (pd == DEPTH_24) ? (word & 32'hFF_FFFF) : word;
         idx = value - cfg_map_first;
         if (value < cfg_map_first || idx >= entries_loaded || idx >= PALETTE_SIZE) begin
            err = 1; colour = 32'h0;
         end else begin
            colour = palette_copy[idx];
         end
      end else begin
         colour = pixel_to_bgra(word, pd, 1'b0);
      end
      if (rle && packet_left > 0) begin
         if (packet_is_repeat) begin
            count = packet_left;
            packet_left = 0;
         end else begin
            packet_left--;
         end
      end
      split_run(count, colour, err);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: drives pending_bytes onto req_, predicts on every accepted byte
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stream_byte_t nb;
      logic drive_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_data_byte, req_image_start);
         // a new transaction may start when the channel is empty or just moved one
         if (!req_valid || req_ready) begin
            drive_next = pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct;
            if (drive_next) begin
               nb = pending_bytes.pop_front();
               req_data_byte <= nb.data_byte;
               req_image_start <= nb.image_start;
            end
            req_valid <= drive_next;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: random backpressure, field-by-field compare
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      segment_t got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= idle_pct;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_blue, rsp_green, rsp_red, rsp_alpha, rsp_dest_row, rsp_column,
                    rsp_run_length, rsp_last_segment, rsp_image_done, rsp_index_error};
            if (expected_segments.size() == 0) begin
               error_count++;
               $display("%0t: unexpected segment, expected none, actual %p", $time, got);
            end else begin
               want = expected_segments.pop_front();
               if (got.blue !== want.blue || got.green !== want.green ||
                   got.red !== want.red || got.alpha !== want.alpha) begin
                  error_count++;
                  $display("%0t: colour mismatch, expected BGRA %h %h %h %h, actual %h %h %h %h",
                           $time, want.blue, want.green, want.red, want.alpha,
                           got.blue, got.green, got.red, got.alpha);
               end
               if (got.dest_row !== want.dest_row || got.column !== want.column ||
                   got.run_length !== want.run_length) begin
                  error_count++;
                  $display("%0t: placement mismatch, expected row %0d col %0d len %0d, actual row %0d col %0d len %0d",
                           $time, want.dest_row, want.column, want.run_length,
                           got.dest_row, got.column, got.run_length);
               end
               if (got.last_segment !== want.last_segment ||
                   got.image_done !== want.image_done ||
                   got.index_error !== want.index_error) begin
                  error_count++;
                  $display("%0t: flag mismatch, expected last/done/err %b%b%b, actual %b%b%b",
                           $time, want.last_segment, want.image_done, want.index_error,
                           got.last_segment, got.image_done, got.index_error);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tga_pixel_stream_decoder verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [2:0] reg_index, int unsigned value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // register takes the value at this edge
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (reg_index)
         REG_KIND:   cfg_kind = value & 7;
         REG_PDEPTH: cfg_pixel_depth = value & 7;
         REG_MDEPTH: cfg_map_depth = value & 7;
         REG_MFIRST: cfg_map_first = value & 8'hFF;
         REG_MCOUNT: cfg_map_count = value & 9'h1FF;
         REG_WIDTH:  cfg_width = value & 13'h1FFF;
         REG_HEIGHT: cfg_height = value & 13'h1FFF;
         REG_LAYOUT: cfg_layout = value & 7;
         default: ;
      endcase
   endtask

   task automatic set_all(int unsigned kind, int unsigned pdepth, int unsigned mdepth,
                          int unsigned mfirst, int unsigned mcount, int unsigned w,
                          int unsigned h, int unsigned layout);
      csr_write(REG_KIND, kind);
      csr_write(REG_PDEPTH, pdepth);
      csr_write(REG_MDEPTH, mdepth);
      csr_write(REG_MFIRST, mfirst);
      csr_write(REG_MCOUNT, mcount);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_LAYOUT, layout);
   endtask

   function automatic void queue_byte(logic [7:0] b, logic start = 1'b0);
      stream_byte_t sb;
      sb.data_byte = b;
      sb.image_start = start;
      pending_bytes.insert(pending_bytes.size(), sb);
   endfunction

   // block until every queued byte is taken and every segment is back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() > 0 || req_valid || expected_segments.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one pixel; mapped kinds mostly get indices near the loaded map
   function automatic void queue_pixel(int unsigned kind, int unsigned pdepth,
                                       int unsigned mfirst, int unsigned mcount);
      int unsigned nb;
      bit mapped;
      nb = bytes_per_pixel(pdepth);
      mapped = (kind == 0) || (kind == 3);
      for (int i = 0; i < nb; i++) begin
         if (mapped && $urandom_range(0, 9) < 8)
            queue_byte((i == 0) ? 8'(mfirst + $urandom_range(0, mcount + 1)) : 8'h00);
         else
            queue_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // a well-formed image body with random content, sprinkled with noise bytes
   function automatic void queue_body(int unsigned kind, int unsigned pdepth,
                                      int unsigned mfirst, int unsigned mcount,
                                      int unsigned packets);
      int unsigned cnt;
      bit rep;
      for (int p = 0; p < packets; p++) begin
         if ($urandom_range(0, 19) == 0) queue_byte(8'($urandom_range(0, 255)));
         if (kind >= 3) begin
            rep = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 4);
            if (!rep && cnt > 6) cnt = 6;
            queue_byte({rep, 7'(cnt)});
            for (int i = 0; i < (rep ? 1 : cnt + 1); i++)
               queue_pixel(kind, pdepth, mfirst, mcount);
         end else begin
            queue_pixel(kind, pdepth, mfirst, mcount);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned kind, pdepth, mdepth, mfirst, mcount;
      bit restart;
      clear_decode();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // mapped 8-bit pixels, 16-bit map with alpha bit; indices below, inside
      // and above the loaded map; bytes after the image ends are dropped
      set_all(0, DEPTH_8, DEPTH_16, 2, 4, 4, 2, 0);
      queue_byte(8'h00, 1'b1); queue_byte(8'h80);
      queue_byte(8'hFF); queue_byte(8'h7F);
      queue_byte(8'h1F); queue_byte(8'h00);
      queue_byte(8'hE0); queue_byte(8'h83);
      queue_byte(8'h02); queue_byte(8'h05); queue_byte(8'h00); queue_byte(8'h06);
      queue_byte(8'h03); queue_byte(8'hFF); queue_byte(8'h04); queue_byte(8'h01);
      queue_byte(8'h33);
      wait_idle();

      // empty map, run-length grey: a 128-pixel run cut at the image end,
      // two-way interleave with top origin, then a fresh two-pixel raw packet
      set_all(5, DEPTH_8, DEPTH_8, 0, 0, 4, 3, 3);
      queue_byte(8'hFF, 1'b1); queue_byte(8'hAA); queue_byte(8'h12);
      queue_byte(8'h01, 1'b1); queue_byte(8'h00); queue_byte(8'hFF);
      wait_idle();

      // 24-bit truecolour left mid-pixel, then run-length switched on
      set_all(1, DEPTH_24, DEPTH_24, 0, 0, 4, 2, 2);
      queue_byte(8'h11, 1'b1);
      wait_idle();
      csr_write(REG_KIND, 4);
      queue_byte(8'h22); queue_byte(8'h33);
      wait_idle();

      // extremes with no idling: short map at the top index, saturated sizes,
      // unknown kind and depth codes, four-way interleave
      idle_pct = 0;
      set_all(7, 7, DEPTH_8, 255, 2, 8191, 0, 4);
      queue_byte(8'h00, 1'b1); queue_byte(8'h01);
      queue_byte(8'h81);
      queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h03); queue_byte(8'h04);
      queue_byte(8'h00);
      queue_byte(8'hFE); queue_byte(8'hFD); queue_byte(8'hFC); queue_byte(8'hFB);
      wait_idle();
      set_all(6, DEPTH_15, 5, 0, 1, 0, 8191, 6);
      queue_byte(8'h55, 1'b1); queue_byte(8'hAA); queue_byte(8'h0F); queue_byte(8'h00);
      queue_byte(8'hFF); queue_byte(8'h7F); queue_byte(8'h83);
      queue_byte(8'h12); queue_byte(8'h34);
      wait_idle();
      idle_pct = 20;

      // random images; some continue the previous one under a new setting
      for (int ph = 0; ph < 3; ph++) begin
         kind = $urandom_range(0, 7);
         pdepth = $urandom_range(0, 7);
         mdepth = $urandom_range(0, 7);
         mcount = $urandom_range(0, 4);
         mfirst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
         restart = ph == 0 || $urandom_range(0, 9) >= 3;
         set_all(kind, pdepth, mdepth, mfirst, mcount,
                 $urandom_range(4, 9), $urandom_range(1, 5), $urandom_range(0, 7));
         if (restart) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            for (int i = 1; i < mcount * bytes_per_pixel(mdepth); i++)
               queue_byte(8'($urandom_range(0, 255)));
         end
         queue_body(kind, pdepth, mfirst, mcount, $urandom_range(2, 4));
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tga_pixel_stream_decoder verification clean");
      end else begin
         $display("tga_pixel_stream_decoder verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+design
design/tpd_pkg.sv
design/tpd_ram.sv
design/tga_pixel_stream_decoder.sv
test/tga_pixel_stream_decoder_tb.sv
